### hdl/rsqa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsqa_pkg;

  // Array geometry.
  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned WIDTH  = 32;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = ADDR_W + 1;

  // Operation codes.
  localparam logic [2:0] MODE_PUSH = 3'd0;
  localparam logic [2:0] MODE_POP  = 3'd1;
  localparam logic [2:0] MODE_GET  = 3'd2;
  localparam logic [2:0] MODE_SET  = 3'd3;
  localparam logic [2:0] MODE_SUM  = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_FULL         = 3'd1;
  localparam logic [2:0] ST_EMPTY        = 3'd2;
  localparam logic [2:0] ST_OUT_OF_SIZE  = 3'd3;
  localparam logic [2:0] ST_OUT_OF_ORDER = 3'd4;

  // Configuration register map (byte addresses).
  localparam int unsigned PADDR_W  = 3;
  localparam logic [PADDR_W-1:0] REG_CAPACITY = 3'd0;
  localparam int unsigned CAP_W    = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // Request beat.
  typedef struct packed {
    logic [2:0]               mode;
    logic [ADDR_W-1:0]        index;
    logic [ADDR_W-1:0]        end_index;
    logic signed [WIDTH-1:0]  value;
  } in_t;

  // Response beat.
  typedef struct packed {
    logic [2:0]               status;
    logic signed [WIDTH-1:0]  result_value;
    logic [CNT_W-1:0]         fill_count;
  } out_t;

endpackage

`default_nettype wire

### hdl/rsqa_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module rsqa_regs
  import rsqa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  output logic      [CAP_W-1:0]   capacity_o
);

  logic [CAP_W-1:0] capacity_q;
  logic             wr_en;

  // The port never inserts wait states.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (wr_en && (paddr == REG_CAPACITY)) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  // Read-back; unmapped addresses read as zero.
  always_comb begin
    unique case (paddr)
      REG_CAPACITY: prdata = {{(32-CAP_W){1'b0}}, capacity_q};
      default:      prdata = '0;
    endcase
  end

  assign capacity_o = capacity_q;

endmodule

`default_nettype wire

### hdl/range_sum_query_array_top.sv
// Channel   Direction  Handshake                Beat
// in        input      in_valid_i / in_ready_o  in_data_i  (rsqa_pkg::in_t)
// out       output     out_valid_o / out_ready_i out_data_o (rsqa_pkg::out_t)
// cfg       input      APB psel/penable/pready  capacity at byte address 0
//
// Push, set, unused codes and every error give a registered result in the cycle after the beat.
// Get and pop pass through the read and done states: the single memory read port returns one entry.
// A range sum walks its N entries in the sum state, then the done state; the read port yields one entry a cycle.
// One item is in flight at a time; the output register lets the next beat in
// as soon as the current result is taken, even in the same cycle.
// Reset clears the fill count and sets capacity to 1024; the memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module range_sum_query_array_top
  import rsqa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_t                in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_t                    out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SUM,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    K_IMM,
    K_READ,
    K_SUM
  } kind_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [WIDTH-1:0]  acc_q;
  logic [ADDR_W-1:0] ptr_q;
  logic [CNT_W-1:0]  left_q;
  logic              out_valid_q;
  out_t              out_q;

  logic [CAP_W-1:0]  capacity;
  logic [CNT_W-1:0]  cap_eff;
  logic              out_free;
  logic              in_acc;
  logic              out_load;

  logic [2:0]        dec_status;
  logic [CNT_W-1:0]  dec_count;
  kind_e             dec_kind;
  logic [CNT_W-1:0]  dec_span;

  logic [WIDTH-1:0]  mem_q [DEPTH];
  logic [WIDTH-1:0]  mem_rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ADDR_W-1:0] start_addr;

  rsqa_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  // Capacity saturates at the memory depth.
  assign cap_eff = (capacity > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity;

  // The output register is free when empty or being drained this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // Decode the incoming operation against the current fill count.
  always_comb begin
    dec_status = ST_OK;
    dec_count  = count_q;
    dec_kind   = K_IMM;
    mem_we     = 1'b0;
    mem_waddr  = in_data_i.index;
    start_addr = in_data_i.index;
    dec_span   = {1'b0, in_data_i.end_index} - {1'b0, in_data_i.index} + CNT_W'(1);
    case (in_data_i.mode)
      MODE_PUSH: begin
        if (count_q >= cap_eff) begin
          dec_status = ST_FULL;
        end else begin
          mem_we    = in_acc;
          mem_waddr = count_q[ADDR_W-1:0];
          dec_count = count_q + CNT_W'(1);
        end
      end
      MODE_POP: begin
        if (count_q == '0) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_count  = count_q - CNT_W'(1);
          start_addr = dec_count[ADDR_W-1:0];
          dec_kind   = K_READ;
        end
      end
      MODE_GET: begin
        if ({1'b0, in_data_i.index} >= count_q) begin
          dec_status = ST_OUT_OF_SIZE;
        end else begin
          dec_kind = K_READ;
        end
      end
      MODE_SET: begin
        if ({1'b0, in_data_i.index} >= count_q) begin
          dec_status = ST_OUT_OF_SIZE;
        end else begin
          mem_we = in_acc;
        end
      end
      MODE_SUM: begin
        if ({1'b0, in_data_i.end_index} >= count_q) begin
          dec_status = ST_OUT_OF_SIZE;
        end else if (in_data_i.index > in_data_i.end_index) begin
          dec_status = ST_OUT_OF_ORDER;
        end else begin
          dec_kind = K_SUM;
        end
      end
      default: begin
        dec_status = ST_OK;
      end
    endcase
  end

  // A result enters the output register on an immediate beat or at the end of a read.
  assign out_load = ((state_q == S_IDLE) && in_acc && (dec_kind == K_IMM)) ||
                    ((state_q == S_DONE) && out_free);

  // The first read is issued with the beat; later reads follow the walk pointer.
  assign mem_raddr = (state_q == S_IDLE) ? start_addr : ptr_q;

  // Entry store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= in_data_i.value;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  // Sequencer, fill count and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      acc_q       <= '0;
      ptr_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // A new result sets the valid flag; a taken result clears it.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            count_q <= dec_count;
            acc_q   <= '0;
            ptr_q   <= start_addr + ADDR_W'(1);
            left_q  <= dec_span;
            unique case (dec_kind)
              K_READ: begin
                state_q <= S_READ;
              end
              K_SUM: begin
                state_q <= S_SUM;
              end
              default: begin
                out_q.status       <= dec_status;
                out_q.result_value <= '0;
                out_q.fill_count   <= dec_count;
              end
            endcase
          end
        end
        S_READ: begin
          acc_q   <= mem_rdata_q;
          state_q <= S_DONE;
        end
        S_SUM: begin
          acc_q  <= acc_q + mem_rdata_q;
          ptr_q  <= ptr_q + ADDR_W'(1);
          left_q <= left_q - CNT_W'(1);
          if (left_q == CNT_W'(1)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_q.status       <= ST_OK;
            out_q.result_value <= acc_q;
            out_q.fill_count   <= count_q;
            state_q            <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The fill count never passes the memory depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // A result waiting in the output register reports the current fill count.
  a_out_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.fill_count == count_q))
    else $error("result fill count differs from state");

  // A range walk always has entries left to add.
  a_sum_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) |-> (left_q != '0))
    else $error("range walk with no entries left");

  // An accepted push that is not full grows the array by one.
  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.mode == MODE_PUSH) && (count_q < cap_eff))
      |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("push did not grow the array");

endmodule

`default_nettype wire
